FILE: hdl/ae16_pkg.sv
// Shared types and constants for the 16-bit static-model arithmetic encoder.
package ae16_pkg;

    // Field widths of the stream items
    localparam int IDX_W       = 10;
    localparam int TOT_W       = 14;
    localparam int SYM_W       = 10;
    localparam int CODE_W      = 16;
    localparam int FOLLOW_W    = 17;
    localparam int RANGE_W     = 17;
    localparam int PROD_W      = RANGE_W + TOT_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // Depth of the command queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Interval constants of the coding scheme
    localparam logic [CODE_W-1:0]  HIGH_INIT  = 16'hFFFF;
    localparam logic [CODE_W-1:0]  PEND_MAX   = 16'hFFFF;
    localparam logic [RANGE_W-1:0] RANGE_FULL = 17'h10000;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INIT   = 2'd1,
        REQ_ENCODE = 2'd2,
        REQ_FLUSH  = 2'd3
    } req_kind_t;

    // One classified command passed from the front part to the back part
    typedef struct packed {
        req_kind_t         kind;
        logic [IDX_W-1:0]  table_index;
        logic [TOT_W-1:0]  total_value;
        logic [SYM_W-1:0]  symbol;
    } ae16_cmd_t;

endpackage

FILE: hdl/arithmetic_encoder_16bit_top.sv
// Top level of the 16-bit static-model arithmetic encoder.
//
// Input transactions arrive on s_axis; tuser carries the request kind (load table entry,
// init, encode symbol, flush) and tdata the table index, total and symbol. Results leave
// on m_axis, one per emitted run: tdata holds the lead bit and the follow count, tlast
// marks the final result caused by one input transaction. max_symbol is written through
// cfg_we and cfg_wdata while the block is idle.
// Loads, inits and flushes are handled in the idle state of the back part. An encode
// runs through S_SCALE, S_HITOT, S_LOTOT, S_DIVGO, S_DIV and S_NORM, staying in S_NORM for
// each renormalisation shift; the 31-step serial division of both scaled bounds dominates.
// Each result is held until the next is known, then registered for output; the last result
// of an encode waits until renormalisation ends so that tlast can be set.
// A four-entry queue decouples input from processing, so input is taken while an encode
// runs until the queue fills. When the receiver stalls, the output register holds its
// transaction and the back part waits for the next one it must emit.
// Reset clears the interval to the full range, the pending count and max_symbol; the
// totals table is not cleared and must be loaded before encoding.
module arithmetic_encoder_16bit_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [9:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata fields from bit 0: table_index[9:0], total_value[13:0], symbol[9:0], zero pad
    input  logic [39:0]  s_axis_tdata,
    // tuser fields from bit 0: req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata fields from bit 0: lead_bit, follow_count[16:0], zero pad
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import ae16_pkg::*;

    logic [SYM_W-1:0]  max_symbol_reg;
    logic              cmd_valid;
    logic              cmd_ready;
    ae16_cmd_t         cmd;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_symbol_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_symbol_reg <= cfg_wdata;
        end
    end

    ae16_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_symbol    (max_symbol_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    ae16_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_symbol    (max_symbol_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: hdl/ae16_front.sv
// Front part: accepts input transactions, drops requests with no effect and queues the rest.
module ae16_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ae16_pkg::SYM_W-1:0]        max_symbol,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata fields from bit 0: table_index[9:0], total_value[13:0], symbol[9:0], zero pad
    input  logic [ae16_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser fields from bit 0: req_type[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output ae16_pkg::ae16_cmd_t               cmd
);
    import ae16_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = 15;

    ae16_cmd_t          in_cmd;
    logic               keep;
    logic               push;
    logic               pop;
    ae16_cmd_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Unpack the incoming transaction
    always_comb
    begin
        in_cmd.kind        = req_kind_t'(s_axis_tuser);
        in_cmd.table_index = s_axis_tdata[9:0];
        in_cmd.total_value = s_axis_tdata[23:10];
        in_cmd.symbol      = s_axis_tdata[33:24];
    end

    // Loads outside the table and symbols beyond the end-of-stream code are dropped here.
    always_comb
    begin
        case (in_cmd.kind)
            REQ_LOAD:   keep = {{(CMP_W-IDX_W){1'b0}}, in_cmd.table_index} < CMP_W'(TABLE_DEPTH);
            REQ_ENCODE: keep = {1'b0, in_cmd.symbol} <= ({1'b0, max_symbol} + 11'd1);
            default:    keep = 1'b1;
        endcase
    end

    assign s_axis_tready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign cmd_valid     = count_reg != '0;
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = queue_mem[rd_ptr_reg];

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hdl/ae16_div.sv
// Restoring divider, one quotient bit per cycle, low quotient bits returned.
module ae16_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ae16_pkg::PROD_W-1:0] dividend,
    input  logic [ae16_pkg::TOT_W-1:0]  divisor,
    output logic                        done,
    output logic [ae16_pkg::CODE_W-1:0] quotient
);
    import ae16_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [TOT_W-1:0]    rem_reg, rem_next;
    logic [TOT_W-1:0]    dvs_reg, dvs_next;
    logic [TOT_W:0]      trial;
    logic [TOT_W:0]      diff;
    logic                fits;

    // One trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(PROD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[PROD_W-2:0], fits};
            rem_next  = fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[CODE_W-1:0];

endmodule

FILE: hdl/ae16_back.sv
// Back part: totals table, interval arithmetic, renormalisation and the output register.
module ae16_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ae16_pkg::SYM_W-1:0]         max_symbol,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  ae16_pkg::ae16_cmd_t                cmd,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata fields from bit 0: lead_bit, follow_count[16:0], zero pad
    output logic [ae16_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);
    import ae16_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int RIX_W = SYM_W + 1;
    localparam int IW    = ((AW > RIX_W) ? AW : RIX_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_HITOT = 7'b0000100,
        S_LOTOT = 7'b0001000,
        S_DIVGO = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_NORM  = 7'b1000000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [CODE_W-1:0]    low_reg, low_next;
    logic [CODE_W-1:0]    high_reg, high_next;
    logic [CODE_W-1:0]    pend_reg, pend_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic [TOT_W-1:0]     scale_reg, scale_next;
    logic [RANGE_W-1:0]   range_reg, range_next;
    logic [PROD_W-1:0]    prod_hi_reg, prod_hi_next;
    logic [PROD_W-1:0]    prod_lo_reg, prod_lo_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 held_lead_reg, held_lead_next;
    logic [CODE_W-1:0]    held_cnt_reg, held_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_lead_reg;
    logic [FOLLOW_W-1:0]  out_cnt_reg;
    logic                 out_last_reg;

    logic [TOT_W-1:0]     table_mem [TABLE_DEPTH];
    logic [TOT_W-1:0]     rd_data_reg;
    logic                 rd_ok_reg;
    logic [RIX_W-1:0]     rd_idx;
    logic [IW-1:0]        rd_idx_w;
    logic [IW-1:0]        wr_idx_w;
    logic                 mem_we;
    logic [TOT_W-1:0]     tot_c;

    logic [RANGE_W-1:0]   diff_c;
    logic [RANGE_W-1:0]   range_c;
    logic                 slot_free;
    logic                 push;
    logic                 push_lead;
    logic [FOLLOW_W-1:0]  push_cnt;
    logic                 push_last;
    logic                 div_start;
    logic                 div_done_hi, div_done_lo;
    logic [CODE_W-1:0]    q_hi, q_lo;

    // Totals table: one write and one read per cycle, read data registered
    assign rd_idx_w = IW'(rd_idx);
    assign wr_idx_w = IW'(cmd.table_index);
    assign tot_c    = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_idx_w[AW-1:0]] <= cmd.total_value;
        end
        rd_data_reg <= table_mem[rd_idx_w[AW-1:0]];
        rd_ok_reg   <= rd_idx_w < IW'(TABLE_DEPTH);
    end

    // Interval width, wrapping as a 16-bit difference when low lies above high
    assign diff_c  = {1'b0, high_reg} - {1'b0, low_reg} + RANGE_W'(1);
    assign range_c = (diff_c > RANGE_FULL) ? {1'b0, diff_c[CODE_W-1:0]} : diff_c;

    assign slot_free = !out_valid_reg || m_axis_tready;

    // Two dividers work on the upper and lower bound in parallel
    ae16_div u_div_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_hi_reg),
        .divisor  (scale_reg),
        .done     (div_done_hi),
        .quotient (q_hi)
    );

    ae16_div u_div_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_lo_reg),
        .divisor  (scale_reg),
        .done     (div_done_lo),
        .quotient (q_lo)
    );

    // Command sequencer
    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        pend_next       = pend_reg;
        sym_next        = sym_reg;
        scale_next      = scale_reg;
        range_next      = range_reg;
        prod_hi_next    = prod_hi_reg;
        prod_lo_next    = prod_lo_reg;
        held_valid_next = held_valid_reg;
        held_lead_next  = held_lead_reg;
        held_cnt_next   = held_cnt_reg;
        cmd_ready       = 1'b0;
        mem_we          = 1'b0;
        div_start       = 1'b0;
        push            = 1'b0;
        push_lead       = 1'b0;
        push_cnt        = '0;
        push_last       = 1'b0;
        rd_idx          = {1'b0, max_symbol} + RIX_W'(2);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        REQ_LOAD:
                        begin
                            cmd_ready = 1'b1;
                            mem_we    = 1'b1;
                        end
                        REQ_INIT:
                        begin
                            cmd_ready = 1'b1;
                            low_next  = '0;
                            high_next = HIGH_INIT;
                            pend_next = '0;
                        end
                        REQ_ENCODE:
                        begin
                            // The scale entry is read at this edge.
                            cmd_ready  = 1'b1;
                            sym_next   = cmd.symbol;
                            state_next = S_SCALE;
                        end
                        REQ_FLUSH:
                        begin
                            if (slot_free)
                            begin
                                cmd_ready = 1'b1;
                                push      = 1'b1;
                                push_lead = low_reg[14];
                                push_cnt  = {1'b0, pend_reg} + FOLLOW_W'(1);
                                push_last = 1'b1;
                                pend_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCALE:
            begin
                rd_idx = {1'b0, sym_reg} + RIX_W'(1);
                if (tot_c == '0)
                begin
                    // A zero scale makes the encode a no-op.
                    state_next = S_IDLE;
                end
                else
                begin
                    scale_next = tot_c;
                    range_next = range_c;
                    state_next = S_HITOT;
                end
            end
            S_HITOT:
            begin
                rd_idx       = {1'b0, sym_reg};
                prod_hi_next = PROD_W'(range_reg) * PROD_W'(tot_c);
                state_next   = S_LOTOT;
            end
            S_LOTOT:
            begin
                prod_lo_next = PROD_W'(range_reg) * PROD_W'(tot_c);
                state_next   = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done_hi)
                begin
                    high_next  = low_reg + q_hi - CODE_W'(1);
                    low_next   = low_reg + q_lo;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (high_reg[15] == low_reg[15])
                begin
                    // Matching top bits: the previous result, if any, is not the last one.
                    if (!held_valid_reg || slot_free)
                    begin
                        if (held_valid_reg)
                        begin
                            push     = 1'b1;
                            push_lead = held_lead_reg;
                            push_cnt = {1'b0, held_cnt_reg};
                        end
                        held_valid_next = 1'b1;
                        held_lead_next  = high_reg[15];
                        held_cnt_next   = pend_reg;
                        pend_next       = '0;
                        low_next        = {low_reg[14:0], 1'b0};
                        high_next       = {high_reg[14:0], 1'b1};
                    end
                end
                else if (low_reg[14] && !high_reg[14])
                begin
                    // Underflow: drop the second bit and count a pending follow bit.
                    pend_next = (pend_reg == PEND_MAX) ? pend_reg : pend_reg + CODE_W'(1);
                    low_next  = {1'b0, low_reg[13:0], 1'b0};
                    high_next = {1'b1, high_reg[13:0], 1'b1};
                end
                else
                begin
                    // Renormalisation is over: release the held result as the last one.
                    if (!held_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        push            = 1'b1;
                        push_lead       = held_lead_reg;
                        push_cnt        = {1'b0, held_cnt_reg};
                        push_last       = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            low_reg        <= '0;
            high_reg       <= HIGH_INIT;
            pend_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_reg       <= pend_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        scale_reg     <= scale_next;
        range_reg     <= range_next;
        prod_hi_reg   <= prod_hi_next;
        prod_lo_reg   <= prod_lo_next;
        held_lead_reg <= held_lead_next;
        held_cnt_reg  <= held_cnt_next;
        if (push)
        begin
            out_lead_reg <= push_lead;
            out_cnt_reg  <= push_cnt;
            out_last_reg <= push_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-FOLLOW_W-1){1'b0}}, out_cnt_reg, out_lead_reg};
    assign m_axis_tlast  = out_last_reg;

    // Commands are taken only between encodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == S_IDLE)
        else $error("command taken while an encode is in progress");

    // Both dividers start together and must finish together.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done_hi == div_done_lo)
        else $error("dividers out of step");

    // A division finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done_hi |-> state_reg == S_DIV)
        else $error("division finished outside the wait state");

    // A held result never outlives its renormalisation run.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> state_reg == S_NORM)
        else $error("held result left behind after renormalisation");

endmodule

FILE: tb/arithmetic_encoder_16bit_top_tb.sv
// Self-checking testbench for the 16-bit static-model arithmetic encoder top level.
module arithmetic_encoder_16bit_top_tb;
    import ae16_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 40;
    localparam int PAD_W          = IN_TDATA_W - IDX_W - TOT_W - SYM_W;

    localparam logic [CODE_W-1:0] SECOND_BIT = 16'h4000;
    localparam logic [CODE_W-1:0] LOW_MASK   = 16'h3FFF;

    // One emitted run: lead bit, number of complemented follow bits, end-of-item mark
    typedef struct packed {
        logic                lead;
        logic [FOLLOW_W-1:0] follow;
        logic                last;
    } code_run_t;

    // Scoreboard: mirrors the encoder state and holds the runs still to be seen.
    class run_scoreboard;
        logic [TOT_W-1:0]  totals [TABLE_DEPTH];
        logic [CODE_W-1:0] low;
        logic [CODE_W-1:0] high;
        logic [CODE_W-1:0] pending;
        logic [9:0]        max_sym;
        code_run_t         awaited_runs [$];
        int                failures;

        function new();
            foreach (totals[i])
                totals[i] = '0;
            low      = '0;
            high     = HIGH_INIT;
            pending  = '0;
            max_sym  = '0;
            failures = 0;
        endfunction

        function void set_max_symbol(logic [9:0] value);
            max_sym = value;
        endfunction

        function int outstanding();
            return awaited_runs.size();
        endfunction

        function bit [31:0] read_total(bit [31:0] idx);
            if (idx >= TABLE_DEPTH)
                return 0;
            return {18'd0, totals[idx]};
        endfunction

        // Works out the runs that one accepted request causes.
        function void note_request(req_kind_t kind, logic [IDX_W-1:0] idx,
                                   logic [TOT_W-1:0] tot, logic [SYM_W-1:0] sym);
            bit [31:0] scale;
            bit [31:0] span;
            bit [31:0] q_hi;
            bit [31:0] q_lo;
            bit [31:0] base;
            int        emitted;
            bit        have_run;
            code_run_t run;
            code_run_t held;
            emitted  = 0;
            have_run = 1'b0;
            run      = '0;
            held     = '0;
            case (kind)
                REQ_LOAD:
                begin
                    totals[idx] = tot;
                end
                REQ_INIT:
                begin
                    low     = '0;
                    high    = HIGH_INIT;
                    pending = '0;
                end
                REQ_FLUSH:
                begin
                    run.lead   = low[14];
                    run.follow = {1'b0, pending} + 17'd1;
                    run.last   = 1'b1;
                    awaited_runs.push_back(run);
                    pending = '0;
                end
                default:
                begin
                    // Symbols beyond the end-of-stream symbol leave everything untouched.
                    if ({22'd0, sym} > {22'd0, max_sym} + 32'd1)
                        return;
                    scale = read_total({22'd0, max_sym} + 32'd2);
                    if (scale == 0)
                        return;
                    span = ({16'd0, high} - {16'd0, low} + 32'd1) & 32'h1FFFF;
                    if (span > 32'h10000)
                        span = span & 32'hFFFF;
                    q_hi = (span * read_total({22'd0, sym} + 32'd1)) / scale;
                    q_lo = (span * read_total({22'd0, sym})) / scale;
                    base = {16'd0, low};
                    high = CODE_W'(base + q_hi - 32'd1);
                    low  = CODE_W'(base + q_lo);

                    // Renormalisation: matching top bits emit, straddling intervals underflow.
                    while (1'b1)
                    begin
                        if (high[15] == low[15])
                        begin
                            if (emitted < 16)
                            begin
                                if (have_run)
                                    awaited_runs.push_back(held);
                                held.lead   = high[15];
                                held.follow = {1'b0, pending};
                                held.last   = 1'b0;
                                have_run    = 1'b1;
                                emitted++;
                            end
                            pending = '0;
                        end
                        else if (low[14] && !high[14])
                        begin
                            if (pending != PEND_MAX)
                                pending = pending + 16'd1;
                            low  = low & LOW_MASK;
                            high = high | SECOND_BIT;
                        end
                        else
                            break;
                        low  = low << 1;
                        high = (high << 1) | 16'd1;
                    end
                    if (have_run)
                    begin
                        held.last = 1'b1;
                        awaited_runs.push_back(held);
                    end
                end
            endcase
        endfunction

        // Compares one accepted output transaction with the oldest awaited run.
        function void check_run(logic lead, logic [FOLLOW_W-1:0] follow, logic last);
            code_run_t want;
            if (awaited_runs.size() == 0)
            begin
                if (failures < 10)
                    $display("ERROR: unexpected run lead=%0b follow=%0d last=%0b",
                             lead, follow, last);
                failures++;
                return;
            end
            want = awaited_runs.pop_front();
            if (want.lead !== lead || want.follow !== follow || want.last !== last)
            begin
                if (failures < 10)
                    $display("ERROR: run expected lead=%0b follow=%0d last=%0b, got lead=%0b follow=%0d last=%0b",
                             want.lead, want.follow, want.last, lead, follow, last);
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [9:0]             cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    run_scoreboard sb;
    bit            src_idle     = 1'b1;
    bit            sink_idle    = 1'b1;
    bit            hold_request = 1'b0;
    int            quiet_cycles = 0;

    arithmetic_encoder_16bit_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Monitor: notes accepted requests, checks accepted runs and watches for a hang.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(req_kind_t'(s_axis_tuser), s_axis_tdata[IDX_W-1:0],
                            s_axis_tdata[IDX_W+TOT_W-1:IDX_W],
                            s_axis_tdata[IDX_W+TOT_W+SYM_W-1:IDX_W+TOT_W]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_run(m_axis_tdata[0], m_axis_tdata[FOLLOW_W:1], m_axis_tlast);
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result receiver: random stalls per transaction while sink_idle is set, plus one long hold on request.
    initial
    begin
        int gap;
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = sink_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && m_axis_tvalid) && !hold_request);
        end
    end

    // Offers one request and waits until the block takes it.
    task automatic send_request(input req_kind_t kind, input logic [IDX_W-1:0] idx,
                                input logic [TOT_W-1:0] tot, input logic [SYM_W-1:0] sym);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, sym, tot, idx};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic load_entry(input int unsigned idx, input int unsigned value);
        send_request(REQ_LOAD, IDX_W'(idx), TOT_W'(value), SYM_W'($urandom_range(0, 1023)));
    endtask

    task automatic encode_symbol(input int unsigned sym);
        send_request(REQ_ENCODE, IDX_W'($urandom_range(0, 1023)),
                     TOT_W'($urandom_range(0, 16383)), SYM_W'(sym));
    endtask

    task automatic send_plain(input req_kind_t kind);
        send_request(kind, IDX_W'($urandom_range(0, 1023)), TOT_W'($urandom_range(0, 16383)),
                     SYM_W'($urandom_range(0, 1023)));
    endtask

    // Stops offering, waits for every awaited run, then lets the back part go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_symbol(input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_max_symbol(value);
        cfg_we    <= 1'b0;
    endtask

    // One setting of max_symbol: build a table, load the entries in use, then encode.
    task automatic run_phase(input int unsigned msym, input bit with_hold);
        int unsigned cum [TABLE_DEPTH];
        bit          loaded [TABLE_DEPTH];
        int unsigned usable [$];
        int unsigned fmax;
        int unsigned freq;
        int unsigned s;
        int unsigned pick;
        int          n;
        write_max_symbol(10'(msym));
        fmax = 16000 / (msym + 2);
        if (fmax > 4000)
            fmax = 4000;
        cum[0] = 0;
        for (s = 0; s <= msym + 1; s++)
        begin
            if (s == msym + 1)
                freq = $urandom_range(1, fmax);
            else
                freq = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, fmax);
            cum[s + 1] = cum[s] + freq;
        end
        foreach (loaded[i])
            loaded[i] = (msym <= 40 && i <= msym + 2);
        // Large alphabets: only a few symbol pairs plus both ends of the table.
        if (msym > 40)
        begin
            loaded[0] = 1'b1;
            loaded[1] = 1'b1;
            loaded[2] = 1'b1;
            repeat (8)
            begin
                s = $urandom_range(3, msym - 1);
                loaded[s]     = 1'b1;
                loaded[s + 1] = 1'b1;
            end
            loaded[msym]     = 1'b1;
            loaded[msym + 1] = 1'b1;
            loaded[msym + 2] = 1'b1;
        end
        for (s = 0; s <= msym + 2; s++)
            if (loaded[s])
                load_entry(s, cum[s]);
        for (s = 0; s <= msym + 1; s++)
            if (loaded[s] && loaded[s + 1])
                usable.push_back(s);
        send_plain(REQ_INIT);

        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            if (with_hold && n == 10)
                hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 72)
                encode_symbol(usable[$urandom_range(0, usable.size() - 1)]);
            else if (pick < 78)
                encode_symbol($urandom_range(msym + 2, 1023));
            else if (pick < 86)
                send_plain(REQ_FLUSH);
            else if (pick < 90)
                send_plain(REQ_INIT);
            else if (pick < 94)
            begin
                // Corrupt an entry in use so that the totals become inconsistent.
                s = usable[$urandom_range(0, usable.size() - 1)];
                load_entry(s + $urandom_range(0, 1), $urandom_range(0, 16383));
            end
            else
                encode_symbol(msym + 1);
        end
        encode_symbol(msym + 1);
        send_plain(REQ_FLUSH);
        settle();
    endtask

    // Stimulus.
    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with max_symbol at its reset value of zero.
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        load_entry(2, 0);
        encode_symbol(0);
        load_entry(0, 0);
        load_entry(1, 9000);
        load_entry(2, 16383);
        send_plain(REQ_INIT);
        encode_symbol(0);
        encode_symbol(1);
        encode_symbol(2);
        encode_symbol(1023);
        send_plain(REQ_FLUSH);
        send_plain(REQ_INIT);
        // A tiny share for symbol zero gives long renormalisation runs.
        load_entry(1, 1);
        encode_symbol(0);
        encode_symbol(0);
        send_plain(REQ_FLUSH);
        // Totals above the scale.
        load_entry(1, 16383);
        load_entry(2, 100);
        encode_symbol(0);
        encode_symbol(1);
        send_plain(REQ_FLUSH);
        // A symbol of zero width.
        load_entry(1, 0);
        load_entry(2, 16383);
        encode_symbol(0);
        send_plain(REQ_FLUSH);
        settle();

        // Random part over several alphabet sizes, the extremes among them.
        src_idle = 1'b1;
        sink_idle = 1'b1;
        run_phase(1021, 1'b0);
        src_idle = 1'b0;
        run_phase(5, 1'b0);
        src_idle = 1'b1;
        sink_idle = 1'b0;
        run_phase(0, 1'b0);
        sink_idle = 1'b1;
        run_phase(37, 1'b1);
        run_phase($urandom_range(41, 1020), 1'b0);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        run_phase(1, 1'b0);
        src_idle = 1'b1;
        sink_idle = 1'b1;
        run_phase($urandom_range(2, 40), 1'b0);

        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
